[hdl/npc_pkg.sv]
package npc_pkg;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  bright;
      logic [31:0] ax;
      logic [31:0] ay;
      logic [31:0] az;
      logic [31:0] bx;
      logic [31:0] by;
      logic [31:0] bz;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_bright;
      logic [31:0] px1;
      logic [31:0] py1;
      logic [31:0] pz1;
      logic [31:0] px2;
      logic [31:0] py2;
      logic [31:0] pz2;
   } rsp_payload_type;

   // input primitive codes
   localparam logic [1:0] REQ_POINT = 2'd0;
   localparam logic [1:0] REQ_VECTOR = 2'd1;
   localparam logic [1:0] REQ_CONT = 2'd2;
   localparam logic [1:0] REQ_BAD = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_POINT = 2'd0;
   localparam logic [1:0] KIND_VECTOR = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // datapath operations
   localparam logic [1:0] OP_D100 = 2'd0;
   localparam logic [1:0] OP_INTX = 2'd1;
   localparam logic [1:0] OP_INTY = 2'd2;
   localparam logic [1:0] OP_PRJ = 2'd3;

   localparam int          DistWidth = 31;
   localparam int          NearWidth = 25;
   localparam int          DivInWidth = 66;
   localparam int          DivQWidth = 33;
   localparam logic [30:0] DistReset = 31'd65536;
   localparam logic [24:0] NearReset = 25'd655;
   localparam logic [31:0] CoordMax = 32'h7fff_ffff;
   localparam logic [31:0] CoordMin = 32'h8000_0000;
   // ceil(2^37 / 100): exact division by 100 for any distance below 2^32
   localparam logic [32:0] NearRecip = 33'h0_51eb_851f;
   localparam int          NearShift = 37;

   typedef struct packed {
      logic       accept;
      logic       dec;
      logic       mul;
      logic       div_start;
      logic       wb;
      logic       load_rsp;
      logic [1:0] op;
      logic [1:0] idx;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       dec_drop;
      logic       dec_clip;
      logic [1:0] dec_kind;
      logic [1:0] kind;
      logic       div_done;
      logic       rsp_busy;
   } dp_status_type;

endpackage

[hdl/npc_div.sv]
module npc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [65:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic        ovf,
   output logic [32:0] quot
);
   import npc_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] lo_ff, lo_in;
   logic [32:0] quot_ff, quot_in;
   logic [32:0] dvsr_ff, dvsr_in;
   logic        ovf_ff, ovf_in;
   logic [33:0] trial;
   logic [33:0] diff;
   logic        ge;

   assign trial = {rem_ff, lo_ff[32]};
   assign ge    = trial >= {1'b0, dvsr_ff};
   assign diff  = trial - {1'b0, dvsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      quot_in = quot_ff;
      dvsr_in = dvsr_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(DivQWidth);
         rem_in  = dividend[65:33];
         lo_in   = dividend[32:0];
         dvsr_in = divisor;
         ovf_in  = dividend[65:33] >= divisor;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[32:0] : trial[32:0];
         lo_in   = {lo_ff[31:0], 1'b0};
         quot_in = {quot_ff[31:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      quot_ff <= quot_in;
      dvsr_ff <= dvsr_in;
      ovf_ff  <= ovf_in;
   end

   assign done = done_ff;
   assign ovf  = ovf_ff;
   assign quot = quot_ff;

endmodule

[hdl/npc_datapath.sv]
module npc_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  npc_pkg::ctrl_cmd_type    cmd,
   output npc_pkg::dp_status_type   status,
   input  npc_pkg::req_payload_type req_payload,
   input  logic                     csr_write_enable,
   input  logic [30:0]              csr_write_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output npc_pkg::rsp_payload_type rsp_payload
);
   import npc_pkg::*;

   function automatic logic [32:0] mag33(input logic [32:0] v);
      return v[32] ? (33'd0 - v) : v;
   endfunction

   logic [1:0]  typ_ff;
   logic [7:0]  br_ff;
   logic [31:0] x1_ff, y1_ff, z1_ff, x2_ff, y2_ff, z2_ff;
   logic [31:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic [7:0]  prev_bright_ff;
   logic [30:0] vd_ff;
   logic [24:0] d100_ff;
   logic [1:0]  kind_ff;
   logic        clip_first_ff;
   logic [31:0] p_ff [4];
   logic [65:0] prod_ff;
   logic [32:0] dvsr_ff;
   logic        neg_ff, zx_ff, zz_ff;
   logic [31:0] base_ff;
   logic        rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic [31:0] near32;
   logic        f1, f2;
   logic [1:0]  dec_kind;
   logic        dec_drop, dec_clip;

   logic [32:0] mul_a, mul_b, dvsr_in;
   logic        neg_in, zx_in, zz_in;
   logic [31:0] base_in, sel_x, sel_z;
   logic [32:0] ia, ib, idiff, inum, iden;

   logic        div_done, div_ovf;
   logic [32:0] div_quot;
   logic [31:0] prj_val;
   logic [33:0] int_sum;

   assign near32 = {7'd0, d100_ff};
   assign f1 = $signed(z1_ff) < $signed(near32);
   assign f2 = $signed(z2_ff) < $signed(near32);

   always_comb begin
      dec_kind = KIND_VECTOR;
      dec_drop = f1 && f2;
      dec_clip = f1 ^ f2;
      case (typ_ff)
         REQ_POINT: begin
            dec_kind = KIND_POINT;
            dec_drop = f1;
            dec_clip = 1'b0;
         end
         REQ_CONT: begin
            if (!f1 && !f2) dec_kind = KIND_END;
         end
         REQ_BAD: begin
            dec_kind = KIND_ERROR;
            dec_drop = 1'b0;
            dec_clip = 1'b0;
         end
         default: ;
      endcase
   end

   // operand selection for the shared multiply and divide
   always_comb begin
      case (cmd.idx)
         2'd0:    sel_x = x1_ff;
         2'd1:    sel_x = y1_ff;
         2'd2:    sel_x = x2_ff;
         default: sel_x = y2_ff;
      endcase
      sel_z = cmd.idx[1] ? z2_ff : z1_ff;
      ia    = (cmd.op == OP_INTY) ? {y1_ff[31], y1_ff} : {x1_ff[31], x1_ff};
      ib    = (cmd.op == OP_INTY) ? {y2_ff[31], y2_ff} : {x2_ff[31], x2_ff};
      idiff = ib - ia;
      inum  = {z1_ff[31], z1_ff} - {1'b0, near32};
      iden  = {z1_ff[31], z1_ff} - {z2_ff[31], z2_ff};
      // near plane depth: multiply by the reciprocal of 100
      mul_a   = {2'd0, vd_ff};
      mul_b   = NearRecip;
      dvsr_in = 33'd1;
      neg_in  = 1'b0;
      zx_in   = 1'b0;
      zz_in   = 1'b0;
      base_in = ia[31:0];
      case (cmd.op)
         OP_PRJ: begin
            mul_a   = mag33({sel_x[31], sel_x});
            mul_b   = {2'd0, vd_ff};
            dvsr_in = {1'b0, sel_z};
            neg_in  = sel_x[31];
            zx_in   = sel_x == '0;
            zz_in   = sel_z == '0;
         end
         OP_INTX, OP_INTY: begin
            mul_a   = mag33(inum);
            mul_b   = mag33(idiff);
            dvsr_in = mag33(iden);
            neg_in  = inum[32] ^ idiff[32] ^ iden[32];
         end
         default: ;
      endcase
   end

   npc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (dvsr_ff),
      .done     (div_done),
      .ovf      (div_ovf),
      .quot     (div_quot)
   );

   always_comb begin
      if (zx_ff) begin
         prj_val = '0;
      end else if (zz_ff || div_ovf || (div_quot[32:31] != 2'd0)) begin
         prj_val = neg_ff ? CoordMin : CoordMax;
      end else begin
         prj_val = neg_ff ? (32'd0 - div_quot[31:0]) : div_quot[31:0];
      end
      int_sum = {{2{base_ff[31]}}, base_ff}
              + (neg_ff ? (34'd0 - {1'b0, div_quot}) : {1'b0, div_quot});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff          <= DistReset;
         d100_ff        <= NearReset;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         prev_z_ff      <= '0;
         prev_bright_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) vd_ff <= csr_write_data;
         if (cmd.wb && cmd.op == OP_D100) begin
            d100_ff <= prod_ff[NearShift+NearWidth-1:NearShift];
         end
         if (cmd.accept) begin
            case (req_payload.req_type)
               REQ_POINT: begin
                  prev_x_ff      <= req_payload.ax;
                  prev_y_ff      <= req_payload.ay;
                  prev_z_ff      <= req_payload.az;
                  prev_bright_ff <= req_payload.bright;
               end
               REQ_VECTOR: begin
                  prev_x_ff      <= req_payload.bx;
                  prev_y_ff      <= req_payload.by;
                  prev_z_ff      <= req_payload.bz;
                  prev_bright_ff <= req_payload.bright;
               end
               REQ_CONT: begin
                  prev_x_ff <= req_payload.bx;
                  prev_y_ff <= req_payload.by;
                  prev_z_ff <= req_payload.bz;
               end
               default: ;
            endcase
         end
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end

      if (cmd.accept) begin
         typ_ff <= req_payload.req_type;
         x2_ff  <= req_payload.bx;
         y2_ff  <= req_payload.by;
         z2_ff  <= req_payload.bz;
         if (req_payload.req_type == REQ_CONT) begin
            x1_ff <= prev_x_ff;
            y1_ff <= prev_y_ff;
            z1_ff <= prev_z_ff;
            br_ff <= prev_bright_ff;
         end else begin
            x1_ff <= req_payload.ax;
            y1_ff <= req_payload.ay;
            z1_ff <= req_payload.az;
            br_ff <= req_payload.bright;
         end
      end

      if (cmd.dec) begin
         kind_ff       <= dec_kind;
         clip_first_ff <= f1;
         for (int i = 0; i < 4; i++) p_ff[i] <= '0;
      end

      if (cmd.mul) begin
         prod_ff <= mul_a * mul_b;
         dvsr_ff <= dvsr_in;
         neg_ff  <= neg_in;
         zx_ff   <= zx_in;
         zz_ff   <= zz_in;
         base_ff <= base_in;
      end

      if (cmd.wb) begin
         case (cmd.op)
            OP_PRJ: p_ff[cmd.idx] <= prj_val;
            OP_INTX: begin
               if (clip_first_ff) x1_ff <= int_sum[31:0];
               else x2_ff <= int_sum[31:0];
            end
            OP_INTY: begin
               // clipped end lands on the near plane
               if (clip_first_ff) begin
                  y1_ff <= int_sum[31:0];
                  z1_ff <= near32;
               end else begin
                  y2_ff <= int_sum[31:0];
                  z2_ff <= near32;
               end
            end
            default: ;
         endcase
      end

      if (cmd.load_rsp) begin
         rsp_ff.kind       <= kind_ff;
         rsp_ff.out_bright <= (kind_ff == KIND_POINT || kind_ff == KIND_VECTOR) ? br_ff : 8'd0;
         rsp_ff.px1        <= p_ff[0];
         rsp_ff.py1        <= p_ff[1];
         rsp_ff.pz1        <= (kind_ff == KIND_POINT || kind_ff == KIND_VECTOR) ? z1_ff : '0;
         rsp_ff.px2        <= p_ff[2];
         rsp_ff.py2        <= p_ff[3];
         rsp_ff.pz2        <= (kind_ff == KIND_END || kind_ff == KIND_VECTOR) ? z2_ff : '0;
      end
   end

   assign status.dec_drop = dec_drop;
   assign status.dec_clip = dec_clip;
   assign status.dec_kind = dec_kind;
   assign status.kind     = kind_ff;
   assign status.div_done = div_done;
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hdl/npc_ctrl.sv]
module npc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   csr_write_enable,
   input  npc_pkg::dp_status_type status,
   output npc_pkg::ctrl_cmd_type  cmd
);
   import npc_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;
   localparam logic [2:0] S_WB   = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] last_idx;

   assign req_ready = (state_ff == S_IDLE) && !csr_write_enable;
   assign last_idx  = (status.kind == KIND_POINT) ? 2'd1 : 2'd3;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (csr_write_enable) begin
               // recompute the near plane depth
               op_in    = OP_D100;
               state_in = S_MUL;
            end else if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DEC;
            end
         end
         S_DEC: begin
            cmd.dec = 1'b1;
            if (status.dec_kind == KIND_ERROR) begin
               state_in = S_OUT;
            end else if (status.dec_drop) begin
               state_in = S_IDLE;
            end else if (status.dec_clip) begin
               op_in    = OP_INTX;
               state_in = S_MUL;
            end else begin
               op_in    = OP_PRJ;
               idx_in   = (status.dec_kind == KIND_END) ? 2'd2 : 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            // the near plane depth needs only the product
            if (op_ff == OP_D100) state_in = S_WB;
            else state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (status.div_done) state_in = S_WB;
         end
         S_WB: begin
            cmd.wb = 1'b1;
            case (op_ff)
               OP_D100: state_in = S_IDLE;
               OP_INTX: begin
                  op_in    = OP_INTY;
                  state_in = S_MUL;
               end
               OP_INTY: begin
                  op_in    = OP_PRJ;
                  idx_in   = 2'd0;
                  state_in = S_MUL;
               end
               default: begin
                  if (idx_ff == last_idx) begin
                     state_in = S_OUT;
                  end else begin
                     idx_in   = idx_ff + 2'd1;
                     state_in = S_MUL;
                  end
               end
            endcase
         end
         S_OUT: begin
            // hold the result until the output register frees up
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      cmd.op  = op_ff;
      cmd.idx = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_PRJ;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         idx_ff   <= idx_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !status.rsp_busy)
      else $error("result loaded while output register is stalled");

   a_done_wb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && status.div_done) |=> state_ff == S_WB)
      else $error("divider result not written back");

   a_accept_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == S_DEC && cmd.dec))
      else $error("accepted transaction not decoded");

endmodule

[hdl/near_plane_clip_perspective_core.sv]
// Near-plane clip and perspective projection of 3D plot primitives.
// Input channel req_*: one primitive per transaction (point, vector,
// continuation from the last endpoint, or a bad code). Result channel
// rsp_*: zero or one result per primitive; primitives wholly in front of
// the near plane (view_distance / 100) produce nothing.
// csr_write_enable/csr_write_data load view_distance (Q16.16); the write
// starts a recompute of the near plane depth (multiply, then write-back),
// during which req_ready stays low.
// Every multiply-divide runs through one shared 33-bit restoring divider
// (one quotient bit per cycle). A point or a polyline end takes 2 of them,
// an unclipped vector 4, a clipped vector 6; a bad code skips the divider.
// One primitive is in flight at a time. A finished result sits in the
// output register; the next primitive is accepted while it waits, and
// its own result waits until rsp_ready drains the register.
// Reset: view_distance returns to 1.0, the stored endpoint and
// brightness clear to zero, and no result is pending.
module near_plane_clip_perspective_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  npc_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output npc_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write_enable,
   input  logic [30:0]              csr_write_data
);
   import npc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   npc_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .csr_write_enable (csr_write_enable),
      .status           (status),
      .cmd              (cmd)
   );

   npc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );

endmodule

[test/near_plane_clip_perspective_core_checker.sv]
`timescale 1ns / 100ps

module near_plane_clip_perspective_core_checker
   import npc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [30:0]     csr_write_data,
   output int              error_count,
   output int              pending_count
);

   localparam longint CoordTop = 64'sh7fff_ffff;

   longint unsigned view_dist;
   longint          last_x, last_y, last_z;
   logic [7:0]      last_bright;
   rsp_payload_type result_queue[$];

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s got %h, want %h", $realtime, field, got, want);
      error_count++;
   endtask

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [31:0] perspective(longint x, longint z);
      longint unsigned q;
      if (x == 0) return 32'd0;
      if (z <= 0) return x > 0 ? CoordMax : CoordMin;
      q = (magnitude(x) * view_dist) / longint'(z);
      if (q > CoordTop) return x > 0 ? CoordMax : CoordMin;
      return x < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint lerp(longint a, longint b, longint num, longint den);
      longint          d;
      longint unsigned q;
      bit              neg;
      d = b - a;
      q = (magnitude(num) * magnitude(d)) / magnitude(den);
      neg = ((num < 0) != (d < 0)) != (den < 0);
      if (num == 0 || d == 0) return a;
      return neg ? a - longint'(q) : a + longint'(q);
   endfunction

   // clip and project one primitive, updating the stored endpoint
   task automatic clip_project(input req_payload_type r, output bit emits,
                               output rsp_payload_type e);
      longint     x1, y1, z1, x2, y2, z2, near, nx, ny;
      logic [7:0] br;
      x1 = longint'($signed(r.ax));
      y1 = longint'($signed(r.ay));
      z1 = longint'($signed(r.az));
      x2 = longint'($signed(r.bx));
      y2 = longint'($signed(r.by));
      z2 = longint'($signed(r.bz));
      br = r.bright;
      near = longint'(view_dist / 100);
      e = '0;
      emits = 1'b1;
      if (r.req_type == REQ_BAD) begin
         e.kind = KIND_ERROR;
         return;
      end
      if (r.req_type == REQ_POINT) begin
         last_bright = br;
         last_x = x1;
         last_y = y1;
         last_z = z1;
         if (z1 < near) begin
            emits = 1'b0;
            return;
         end
         e.kind = KIND_POINT;
         e.out_bright = br;
         e.px1 = perspective(x1, z1);
         e.py1 = perspective(y1, z1);
         e.pz1 = z1[31:0];
         return;
      end
      if (r.req_type == REQ_VECTOR) begin
         last_bright = br;
      end else begin
         x1 = last_x;
         y1 = last_y;
         z1 = last_z;
         br = last_bright;
      end
      last_x = x2;
      last_y = y2;
      last_z = z2;
      if (r.req_type == REQ_CONT && z1 >= near && z2 >= near) begin
         e.kind = KIND_END;
         e.px2 = perspective(x2, z2);
         e.py2 = perspective(y2, z2);
         e.pz2 = z2[31:0];
         return;
      end
      if (z1 < near && z2 < near) begin
         emits = 1'b0;
         return;
      end
      if (z1 < near || z2 < near) begin
         nx = lerp(x1, x2, z1 - near, z1 - z2);
         ny = lerp(y1, y2, z1 - near, z1 - z2);
         if (z1 < near) begin
            x1 = nx;
            y1 = ny;
            z1 = near;
         end else begin
            x2 = nx;
            y2 = ny;
            z2 = near;
         end
      end
      e.kind = KIND_VECTOR;
      e.out_bright = br;
      e.px1 = perspective(x1, z1);
      e.py1 = perspective(y1, z1);
      e.pz1 = z1[31:0];
      e.px2 = perspective(x2, z2);
      e.py2 = perspective(y2, z2);
      e.pz2 = z2[31:0];
   endtask

   initial error_count = 0;

   assign pending_count = result_queue.size();

   always @(posedge clock) begin
      bit              emits;
      rsp_payload_type want;
      if (reset) begin
         view_dist = 65536;
         last_x = 0;
         last_y = 0;
         last_z = 0;
         last_bright = '0;
         result_queue.delete();
      end else begin
         // compare before predicting: a result never belongs to the same edge's request
         if (rsp_valid && rsp_ready) begin
            if (result_queue.size() == 0) begin
               $display("%0t: result with none expected, kind %0d", $realtime,
                        rsp_payload.kind);
               error_count++;
            end else begin
               want = result_queue.pop_front();
               if (rsp_payload.kind != want.kind) report("kind", rsp_payload.kind, want.kind);
               if (rsp_payload.out_bright != want.out_bright)
                  report("out_bright", rsp_payload.out_bright, want.out_bright);
               if (rsp_payload.px1 != want.px1) report("px1", rsp_payload.px1, want.px1);
               if (rsp_payload.py1 != want.py1) report("py1", rsp_payload.py1, want.py1);
               if (rsp_payload.pz1 != want.pz1) report("pz1", rsp_payload.pz1, want.pz1);
               if (rsp_payload.px2 != want.px2) report("px2", rsp_payload.px2, want.px2);
               if (rsp_payload.py2 != want.py2) report("py2", rsp_payload.py2, want.py2);
               if (rsp_payload.pz2 != want.pz2) report("pz2", rsp_payload.pz2, want.pz2);
            end
         end
         if (req_valid && req_ready) begin
            clip_project(req_payload, emits, want);
            if (emits) result_queue.push_back(want);
         end
         if (csr_write_enable) view_dist = csr_write_data;
      end
   end

endmodule

[test/near_plane_clip_perspective_core_test.sv]
`timescale 1ns / 100ps

module near_plane_clip_perspective_core_test;
   import npc_pkg::*;

   localparam int CycleLimit = 4000000;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable;
   logic [30:0]     csr_write_data;
   int              error_count;
   int              pending_count;
   int              cycle_count = 0;
   int              hold_requests;
   bit              steady;
   longint          near_depth;

   near_plane_clip_perspective_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   near_plane_clip_perspective_core_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("near_plane_clip_perspective_core: mismatch");
         $finish;
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // receiver: random stalls, long hold-offs on request
   always @(posedge clock) begin
      int hold_left, gap_left, holds_done;
      if (holds_done < hold_requests) begin
         holds_done++;
         hold_left = 2000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!steady && $urandom_range(0, 5) == 0) gap_left = pick_gap();
      end
   end

   task automatic send(input req_payload_type item);
      int gap;
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!steady && $urandom_range(0, 3) == 0) begin
         gap = pick_gap();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fields(input logic [1:0] kind, input logic [7:0] br,
                              input longint ax, ay, az, bx, by, bz);
      req_payload_type item;
      item.req_type = kind;
      item.bright = br;
      item.ax = ax[31:0];
      item.ay = ay[31:0];
      item.az = az[31:0];
      item.bx = bx[31:0];
      item.by = by[31:0];
      item.bz = bz[31:0];
      send(item);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // a dropped primitive may still be in the datapath
      repeat (300) @(posedge clock);
   endtask

   task automatic write_distance(input logic [30:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      near_depth = value / 100;
   endtask

   function automatic longint rand_coord();
      case ($urandom_range(0, 4))
         0: return longint'($signed($urandom()));
         1: return longint'($urandom_range(0, 2000)) * 1024 - 1024000;
         2: return $urandom_range(0, 1) ? 64'sh7fff_ffff : -64'sh8000_0000;
         3: return 0;
         default: return longint'($signed($urandom())) >>> $urandom_range(0, 20);
      endcase
   endfunction

   function automatic longint rand_depth();
      longint z;
      case ($urandom_range(0, 5))
         0: z = longint'($signed($urandom()));
         1: z = near_depth + longint'($urandom_range(0, 4000)) - 2000;
         2: z = near_depth;
         3: z = near_depth + longint'($urandom_range(0, 32'h00ff_ffff));
         4: z = near_depth - longint'($urandom_range(1, 32'h00ff_ffff));
         default: z = $urandom_range(0, 1) ? 64'sh7fff_ffff : -64'sh8000_0000;
      endcase
      if (z > 64'sh7fff_ffff) z = 64'sh7fff_ffff;
      if (z < -64'sh8000_0000) z = -64'sh8000_0000;
      return z;
   endfunction

   task automatic random_item();
      logic [1:0] kind;
      int         pick;
      pick = $urandom_range(0, 19);
      if (pick < 5) kind = REQ_POINT;
      else if (pick < 11) kind = REQ_VECTOR;
      else if (pick < 19) kind = REQ_CONT;
      else kind = REQ_BAD;
      send_fields(kind, 8'($urandom_range(0, 255)), rand_coord(), rand_coord(), rand_depth(),
                  rand_coord(), rand_coord(), rand_depth());
   endtask

   task automatic depth_edges();
      // zero depth: saturate toward the sign when the near plane sits at zero
      send_fields(REQ_POINT, 8'h11, 64'sh7fff_ffff, -64'sh8000_0000, 0, 0, 0, 0);
      send_fields(REQ_POINT, 8'h22, 0, 5, 0, 0, 0, 0);
      send_fields(REQ_POINT, 8'h33, 1, -1, near_depth, 0, 0, 0);
      send_fields(REQ_VECTOR, 8'h44, 65536, -65536, near_depth - 1,
                  -65536, 65536, near_depth + 65536);
   endtask

   initial begin
      longint unsigned dist_list[6];
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      hold_requests = 0;
      steady = 1'b0;
      near_depth = 655;
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every code, clipping both ways
      send_fields(REQ_POINT, 8'hff, 64'sh7fff_ffff, -64'sh8000_0000, 64'sh7fff_ffff, 0, 0, 0);
      send_fields(REQ_POINT, 8'h00, -64'sh8000_0000, 64'sh7fff_ffff, 1000, 0, 0, 0);
      send_fields(REQ_POINT, 8'h5a, 3 << 16, 2 << 16, 100, 0, 0, 0);
      send_fields(REQ_VECTOR, 8'h80, 1 << 16, 2 << 16, 4 << 16, -1 << 16, 3 << 16, 8 << 16);
      send_fields(REQ_VECTOR, 8'h81, 5 << 16, -5 << 16, -2 << 16, 7 << 16, 1 << 16, 3 << 16);
      send_fields(REQ_VECTOR, 8'h82, 5 << 16, -5 << 16, 9 << 16, 7 << 16, 1 << 16, -3 << 16);
      send_fields(REQ_VECTOR, 8'h83, 1, 1, -5, 2, 2, -6);
      send_fields(REQ_CONT, 8'h00, 0, 0, 0, 4 << 16, 4 << 16, 2 << 16);
      send_fields(REQ_CONT, 8'h00, 0, 0, 0, -4 << 16, 1 << 16, 3 << 16);
      send_fields(REQ_CONT, 8'h00, 0, 0, 0, 1 << 16, 1 << 16, -3 << 16);
      send_fields(REQ_CONT, 8'h00, 0, 0, 0, 2 << 16, -2 << 16, 6 << 16);
      send_fields(REQ_CONT, 8'h00, 0, 0, 0, 64'sh7fff_ffff, -64'sh8000_0000, 64'sh7fff_ffff);
      send_fields(REQ_BAD, 8'hff, -1, -1, -1, -1, -1, -1);
      send_fields(REQ_CONT, 8'h00, 0, 0, 0, 1 << 16, 1 << 16, 1 << 16);
      depth_edges();

      // pile up behind a stalled receiver, then wait for the queue to empty
      hold_requests++;
      repeat (6) random_item();
      drain();

      dist_list[0] = 65536;
      dist_list[1] = 1;
      dist_list[2] = 31'h7fff_ffff;
      dist_list[3] = 0;
      dist_list[4] = 100 << 16;
      dist_list[5] = $urandom_range(1, 31'h7fff_ffff);
      foreach (dist_list[p]) begin
         if (p > 0) write_distance(dist_list[p]);
         depth_edges();
         for (int n = 0; n < 270; n++) begin
            if (n % 90 == 0) steady = ($urandom_range(0, 2) == 0);
            random_item();
         end
         steady = 1'b0;
         drain();
      end
      write_distance(31'd65536);
      repeat (40) random_item();
      drain();

      if (error_count == 0 && pending_count == 0) begin
         $display("near_plane_clip_perspective_core: match");
      end else begin
         $display("near_plane_clip_perspective_core: mismatch");
      end
      $finish;
   end

endmodule
